[rtl/core/sri_pkg.sv]
// Shared widths, stage payload types and the span check for the segment/rectangle test.
`default_nettype none
package sri_pkg;

  localparam int COORD_BITS = 20;
  localparam int SIZE_BITS  = COORD_BITS - 2;
  localparam int DIFF_BITS  = COORD_BITS + 2;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int WIDE_BITS  = PROD_BITS + 1;
  localparam int SIDES      = 4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] seg_ax;
    logic signed [COORD_BITS-1:0] seg_ay;
    logic signed [COORD_BITS-1:0] seg_bx;
    logic signed [COORD_BITS-1:0] seg_by;
    logic signed [COORD_BITS-1:0] rect_left;
    logic signed [COORD_BITS-1:0] rect_top;
    logic        [SIZE_BITS-1:0]  rect_width;
    logic        [SIZE_BITS-1:0]  rect_height;
  } query_t;

  typedef struct packed {
    logic signed [DIFF_BITS-1:0] ex;
    logic signed [DIFF_BITS-1:0] ey;
    logic        [DIFF_BITS-1:0] ex_abs;
    logic        [DIFF_BITS-1:0] ey_abs;
    logic signed [DIFF_BITS-1:0] ox_l;
    logic signed [DIFF_BITS-1:0] ox_r;
    logic signed [DIFF_BITS-1:0] oy_t;
    logic signed [DIFF_BITS-1:0] oy_b;
    logic        [SIZE_BITS-1:0] w;
    logic        [SIZE_BITS-1:0] h;
  } diff_t;

  typedef struct packed {
    logic signed [PROD_BITS-1:0] p_ex_oyt;
    logic signed [PROD_BITS-1:0] p_ex_oyb;
    logic signed [PROD_BITS-1:0] p_ey_oxl;
    logic signed [PROD_BITS-1:0] p_ey_oxr;
    logic        [PROD_BITS-1:0] bnd_h;
    logic        [PROD_BITS-1:0] bnd_w;
    logic                        ex_neg;
    logic                        ey_neg;
    logic        [SIDES-1:0]     side_a;
  } prod_t;

  typedef struct packed {
    logic signed [PROD_BITS-1:0] n_lt;
    logic signed [PROD_BITS-1:0] n_r;
    logic signed [PROD_BITS-1:0] n_b;
    logic        [PROD_BITS-1:0] bnd_h;
    logic        [PROD_BITS-1:0] bnd_w;
    logic                        ex_neg;
    logic                        ey_neg;
    logic        [SIDES-1:0]     side_a;
  } numer_t;

  typedef struct packed {
    logic             hit;
    logic [SIDES-1:0] side_mask;
  } result_t;

  // True when 0 <= v <= bound, or when -bound <= v <= 0 if flip is set.
  function automatic logic in_span(input logic signed [PROD_BITS-1:0] v,
                                   input logic flip,
                                   input logic [PROD_BITS-1:0] bound);
    logic signed [WIDE_BITS-1:0] vw;
    logic signed [WIDE_BITS-1:0] bw;
    logic signed [WIDE_BITS-1:0] sum;
    vw  = WIDE_BITS'(v);
    bw  = signed'({1'b0, bound});
    sum = vw + bw;
    if (flip) begin
      return (vw <= 0) && (sum >= 0);
    end
    return (vw >= 0) && (vw <= bw);
  endfunction

endpackage
`default_nettype wire

[rtl/core/sri_query_if.sv]
// Query channel carrying one segment and one rectangle per transaction.
`default_nettype none
interface sri_query_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sri_pkg::COORD_BITS-1:0] seg_ax;
  logic signed [sri_pkg::COORD_BITS-1:0] seg_ay;
  logic signed [sri_pkg::COORD_BITS-1:0] seg_bx;
  logic signed [sri_pkg::COORD_BITS-1:0] seg_by;
  logic signed [sri_pkg::COORD_BITS-1:0] rect_left;
  logic signed [sri_pkg::COORD_BITS-1:0] rect_top;
  logic        [sri_pkg::SIZE_BITS-1:0]  rect_width;
  logic        [sri_pkg::SIZE_BITS-1:0]  rect_height;

  modport source (output valid, seg_ax, seg_ay, seg_bx, seg_by, rect_left, rect_top,
                  rect_width, rect_height, input ready);
  modport sink (input valid, seg_ax, seg_ay, seg_bx, seg_by, rect_left, rect_top,
                rect_width, rect_height, output ready);
endinterface
`default_nettype wire

[rtl/core/sri_result_if.sv]
// Result channel carrying the hit flag and side mask per transaction.
`default_nettype none
interface sri_result_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [sri_pkg::SIDES-1:0]   side_mask;

  modport source (output valid, hit, side_mask, input ready);
  modport sink (input valid, hit, side_mask, output ready);
endinterface
`default_nettype wire

[rtl/core/sri_prep.sv]
// First stage: edge vectors, endpoint offsets and magnitudes.
`default_nettype none
module sri_prep (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire sri_pkg::query_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sri_pkg::diff_t       out_data
);

  logic signed [sri_pkg::DIFF_BITS-1:0] ax, ay, bx, by, left, top, right, bottom;
  sri_pkg::diff_t d_next;

  assign ax     = sri_pkg::DIFF_BITS'(in_data.seg_ax);
  assign ay     = sri_pkg::DIFF_BITS'(in_data.seg_ay);
  assign bx     = sri_pkg::DIFF_BITS'(in_data.seg_bx);
  assign by     = sri_pkg::DIFF_BITS'(in_data.seg_by);
  assign left   = sri_pkg::DIFF_BITS'(in_data.rect_left);
  assign top    = sri_pkg::DIFF_BITS'(in_data.rect_top);
  assign right  = left + signed'(sri_pkg::DIFF_BITS'(in_data.rect_width));
  assign bottom = top + signed'(sri_pkg::DIFF_BITS'(in_data.rect_height));

  always_comb begin
    d_next.ex     = bx - ax;
    d_next.ey     = by - ay;
    d_next.ex_abs = d_next.ex[sri_pkg::DIFF_BITS-1] ? unsigned'(-d_next.ex)
                                                   : unsigned'(d_next.ex);
    d_next.ey_abs = d_next.ey[sri_pkg::DIFF_BITS-1] ? unsigned'(-d_next.ey)
                                                   : unsigned'(d_next.ey);
    d_next.ox_l   = ax - left;
    d_next.ox_r   = ax - right;
    d_next.oy_t   = ay - top;
    d_next.oy_b   = ay - bottom;
    d_next.w      = in_data.rect_width;
    d_next.h      = in_data.rect_height;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= d_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/sri_mult.sv]
// Second stage: cross products, side bounds and the first parameter test.
`default_nettype none
module sri_mult (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sri_pkg::diff_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sri_pkg::prod_t      out_data
);

  sri_pkg::prod_t p_next;
  logic           vert_ok, horz_ok, ex_neg, ey_neg;

  assign ex_neg  = in_data.ex[sri_pkg::DIFF_BITS-1];
  assign ey_neg  = in_data.ey[sri_pkg::DIFF_BITS-1];
  assign vert_ok = (in_data.ex != '0) && (in_data.h != '0);
  assign horz_ok = (in_data.ey != '0) && (in_data.w != '0);

  always_comb begin
    p_next.p_ex_oyt = in_data.ex * in_data.oy_t;
    p_next.p_ex_oyb = in_data.ex * in_data.oy_b;
    p_next.p_ey_oxl = in_data.ey * in_data.ox_l;
    p_next.p_ey_oxr = in_data.ey * in_data.ox_r;
    p_next.bnd_h    = sri_pkg::PROD_BITS'(in_data.h) * sri_pkg::PROD_BITS'(in_data.ex_abs);
    p_next.bnd_w    = sri_pkg::PROD_BITS'(in_data.w) * sri_pkg::PROD_BITS'(in_data.ey_abs);
    p_next.ex_neg   = ex_neg;
    p_next.ey_neg   = ey_neg;
    p_next.side_a[0] = vert_ok && sri_pkg::in_span(sri_pkg::PROD_BITS'(in_data.ox_l), !ex_neg,
                                                   sri_pkg::PROD_BITS'(in_data.ex_abs));
    p_next.side_a[1] = vert_ok && sri_pkg::in_span(sri_pkg::PROD_BITS'(in_data.ox_r), !ex_neg,
                                                   sri_pkg::PROD_BITS'(in_data.ex_abs));
    p_next.side_a[2] = horz_ok && sri_pkg::in_span(sri_pkg::PROD_BITS'(in_data.oy_t), !ey_neg,
                                                   sri_pkg::PROD_BITS'(in_data.ey_abs));
    p_next.side_a[3] = horz_ok && sri_pkg::in_span(sri_pkg::PROD_BITS'(in_data.oy_b), !ey_neg,
                                                   sri_pkg::PROD_BITS'(in_data.ey_abs));
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= p_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/sri_decide.sv]
// Third and fourth stages: second-parameter numerators and the final side mask.
`default_nettype none
module sri_decide (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sri_pkg::prod_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sri_pkg::result_t    out_data
);

  sri_pkg::numer_t  numer;
  sri_pkg::numer_t  numer_next;
  sri_pkg::result_t res_next;
  logic             numer_valid;
  logic             numer_ready;

  always_comb begin
    numer_next.n_lt   = in_data.p_ex_oyt - in_data.p_ey_oxl;
    numer_next.n_r    = in_data.p_ex_oyt - in_data.p_ey_oxr;
    numer_next.n_b    = in_data.p_ex_oyb - in_data.p_ey_oxl;
    numer_next.bnd_h  = in_data.bnd_h;
    numer_next.bnd_w  = in_data.bnd_w;
    numer_next.ex_neg = in_data.ex_neg;
    numer_next.ey_neg = in_data.ey_neg;
    numer_next.side_a = in_data.side_a;
  end

  always_comb begin
    res_next.side_mask[0] = numer.side_a[0] &&
                            sri_pkg::in_span(numer.n_lt, numer.ex_neg, numer.bnd_h);
    res_next.side_mask[1] = numer.side_a[1] &&
                            sri_pkg::in_span(numer.n_r, numer.ex_neg, numer.bnd_h);
    res_next.side_mask[2] = numer.side_a[2] &&
                            sri_pkg::in_span(numer.n_lt, !numer.ey_neg, numer.bnd_w);
    res_next.side_mask[3] = numer.side_a[3] &&
                            sri_pkg::in_span(numer.n_b, !numer.ey_neg, numer.bnd_w);
    res_next.hit          = |res_next.side_mask;
  end

  assign in_ready    = !numer_valid || numer_ready;
  assign numer_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      numer_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_ready) begin
        numer_valid <= in_valid;
      end
      if (numer_ready) begin
        out_valid <= numer_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      numer <= numer_next;
    end
    if (numer_valid && numer_ready) begin
      out_data <= res_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/segment_rect_intersect_unit.sv]
// Top level of the segment against axis-aligned rectangle intersection pipeline.
//
// Each query transaction carries one segment (seg_ax, seg_ay to seg_bx, seg_by)
// and one rectangle (rect_left, rect_top, rect_width, rect_height), all in the
// same fixed-point scale. Each result transaction returns side_mask (bit 0 left,
// bit 1 right, bit 2 top, bit 3 bottom) and hit, which is set when any side is
// crossed. Sides parallel to the segment never count as crossed.
// Results leave in the order in which queries arrived, exactly one per query.
// The pipeline has four register stages: offsets, cross products, numerators and
// the final compare. A new query is taken every cycle while the receiver accepts
// results; the multiplier stage sets the clock period.
// When the receiver holds ready low, stages fill up and query.ready drops only
// once every stage holds a pending transaction; nothing is lost or repeated.
// A synchronous reset empties all stages and the block takes queries in the
// next cycle.
`default_nettype none
module segment_rect_intersect_unit (
  input  wire logic     clk,
  input  wire logic     rst,
  sri_query_if.sink     query,
  sri_result_if.source  result
);

  sri_pkg::query_t  q_data;
  sri_pkg::diff_t   diff_data;
  sri_pkg::prod_t   prod_data;
  sri_pkg::result_t res_data;
  logic             diff_valid, diff_ready;
  logic             prod_valid, prod_ready;

  always_comb begin
    q_data.seg_ax      = query.seg_ax;
    q_data.seg_ay      = query.seg_ay;
    q_data.seg_bx      = query.seg_bx;
    q_data.seg_by      = query.seg_by;
    q_data.rect_left   = query.rect_left;
    q_data.rect_top    = query.rect_top;
    q_data.rect_width  = query.rect_width;
    q_data.rect_height = query.rect_height;
  end

  sri_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (query.valid),
    .in_ready  (query.ready),
    .in_data   (q_data),
    .out_valid (diff_valid),
    .out_ready (diff_ready),
    .out_data  (diff_data)
  );

  sri_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (diff_valid),
    .in_ready  (diff_ready),
    .in_data   (diff_data),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  sri_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (res_data)
  );

  assign result.hit       = res_data.hit;
  assign result.side_mask = res_data.side_mask;

endmodule
`default_nettype wire

[rtl/core/sri_checker.sv]
// Port-level checks for the intersection unit and their binding to the top level.
`default_nettype none
module sri_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      q_ready,
  input wire logic                      r_valid,
  input wire logic                      r_ready,
  input wire logic                      hit,
  input wire logic [sri_pkg::SIDES-1:0] side_mask
);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(hit) && $stable(side_mask))
    else $error("result transaction changed while stalled");

  a_hit_matches_mask: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> (hit == (side_mask != '0)))
    else $error("hit flag disagrees with side mask");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !r_valid)
    else $error("result valid right after reset");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !r_valid |-> q_ready)
    else $error("query stalled while the output stage is empty");

endmodule

bind segment_rect_intersect_unit sri_checker u_sri_checker (
  .clk       (clk),
  .rst       (rst),
  .q_ready   (query.ready),
  .r_valid   (result.valid),
  .r_ready   (result.ready),
  .hit       (result.hit),
  .side_mask (result.side_mask)
);
`default_nettype wire
